// ----- rtl/core/rc4_pkg.sv -----
// Shared types and constants for the RC4 stream cipher unit.
// Holds the input and result beat structures and the command and register codes.
// No dependencies.
package rc4_pkg;

  localparam int unsigned PERM_DEPTH = 256;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic CMD_KEY_SETUP = 1'b0;
  localparam logic CMD_DATA      = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [BYTE_W-1:0] keystream_byte;
  } out_beat_t;

endpackage

// ----- rtl/core/rc4_stream_cipher_unit.sv -----
// RC4 stream cipher unit: key registers, one 256 x 8 permutation memory and its sequencer.
// Depends on rc4_pkg for the beat types, command codes and register indexes.
// A data beat steps through ST_D_RD_I, ST_D_RD_J and ST_D_WR_J, which loads the output
// register, or ST_HOLD while that register is full. A new beat is taken only in ST_IDLE,
// set by the memory's single read port and single write port. Key setup gives no result.
// Reset clears the key registers, both indices and the output valid flag; the permutation
// holds no defined contents until the first key setup.
module rc4_stream_cipher_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  rc4_pkg::in_beat_t                      in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output rc4_pkg::out_beat_t                     out_data,
  input  logic                                   cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [rc4_pkg::KEY_W-1:0]              cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_K_RD_N,
    ST_K_RD_J,
    ST_K_WR_N,
    ST_K_WR_J,
    ST_D_RD_I,
    ST_D_RD_J,
    ST_D_WR_J,
    ST_HOLD
  } state_t;

  state_t                       state_r, state_nxt;
  logic [rc4_pkg::KEY_W-1:0]    key_low_r, key_high_r;
  logic [rc4_pkg::BYTE_W-1:0]   cnt_r, cnt_nxt;
  logic [rc4_pkg::BYTE_W-1:0]   gi_r, gi_nxt;
  logic [rc4_pkg::BYTE_W-1:0]   gj_r, gj_nxt;
  logic [rc4_pkg::BYTE_W-1:0]   idx_a_r, idx_a_nxt;
  logic [rc4_pkg::BYTE_W-1:0]   idx_b_r, idx_b_nxt;
  logic [rc4_pkg::BYTE_W-1:0]   idx_t_r, idx_t_nxt;
  logic [rc4_pkg::BYTE_W-1:0]   sa_r, sa_nxt;
  logic [rc4_pkg::BYTE_W-1:0]   sb_r, sb_nxt;
  logic [rc4_pkg::BYTE_W-1:0]   data_r, data_nxt;
  logic [rc4_pkg::BYTE_W-1:0]   ks_r, ks_nxt;
  logic                         out_valid_r, out_valid_nxt;
  rc4_pkg::out_beat_t           out_data_r, out_data_nxt;

  logic [rc4_pkg::BYTE_W-1:0]   perm_mem [rc4_pkg::PERM_DEPTH];
  logic [rc4_pkg::BYTE_W-1:0]   mem_rdata_r;
  logic [rc4_pkg::BYTE_W-1:0]   mem_raddr;
  logic [rc4_pkg::BYTE_W-1:0]   mem_waddr;
  logic [rc4_pkg::BYTE_W-1:0]   mem_wdata;
  logic                         mem_we;

  logic [2*rc4_pkg::KEY_W-1:0]  key_w;
  logic [rc4_pkg::BYTE_W-1:0]   key_byte;
  logic [rc4_pkg::BYTE_W-1:0]   ks_fwd;
  logic                         in_acc;
  logic                         out_free;

  assign key_w    = {key_high_r, key_low_r};
  assign key_byte = key_w[{cnt_r[3:0], 3'b000} +: rc4_pkg::BYTE_W];
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The read of S[t] is issued alongside the write of S[i]; the swap is resolved here.
  always_comb begin
    priority if (idx_t_r == idx_a_r) begin
      ks_fwd = sb_r;
    end else if (idx_t_r == idx_b_r) begin
      ks_fwd = sa_r;
    end else begin
      ks_fwd = mem_rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      perm_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= perm_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rc4_pkg::CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        rc4_pkg::CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    gi_nxt        = gi_r;
    gj_nxt        = gj_r;
    idx_a_nxt     = idx_a_r;
    idx_b_nxt     = idx_b_r;
    idx_t_nxt     = idx_t_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    data_nxt      = data_r;
    ks_nxt        = ks_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_raddr     = gi_r + 8'd1;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.command == rc4_pkg::CMD_KEY_SETUP) begin
            cnt_nxt   = '0;
            state_nxt = ST_INIT;
          end else begin
            idx_a_nxt = gi_r + 8'd1;
            data_nxt  = in_data.data_byte;
            state_nxt = ST_D_RD_I;
          end
        end
      end
      ST_INIT: begin
        mem_we    = 1'b1;
        cnt_nxt   = cnt_r + 8'd1;
        if (cnt_r == 8'hFF) begin
          idx_b_nxt = '0;
          state_nxt = ST_K_RD_N;
        end
      end
      ST_K_RD_N: begin
        mem_raddr = cnt_r;
        state_nxt = ST_K_RD_J;
      end
      ST_K_RD_J: begin
        sa_nxt    = mem_rdata_r;
        idx_b_nxt = idx_b_r + mem_rdata_r + key_byte;
        mem_raddr = idx_b_nxt;
        state_nxt = ST_K_WR_N;
      end
      ST_K_WR_N: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = mem_rdata_r;
        state_nxt = ST_K_WR_J;
      end
      ST_K_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = idx_b_r;
        mem_wdata = sa_r;
        cnt_nxt   = cnt_r + 8'd1;
        if (cnt_r == 8'hFF) begin
          gi_nxt    = '0;
          gj_nxt    = '0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_K_RD_N;
        end
      end
      ST_D_RD_I: begin
        sa_nxt    = mem_rdata_r;
        idx_b_nxt = gj_r + mem_rdata_r;
        mem_raddr = idx_b_nxt;
        state_nxt = ST_D_RD_J;
      end
      ST_D_RD_J: begin
        sb_nxt    = mem_rdata_r;
        idx_t_nxt = sa_r + mem_rdata_r;
        mem_raddr = idx_t_nxt;
        mem_we    = 1'b1;
        mem_waddr = idx_a_r;
        mem_wdata = mem_rdata_r;
        state_nxt = ST_D_WR_J;
      end
      ST_D_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = idx_b_r;
        mem_wdata = sa_r;
        gi_nxt    = idx_a_r;
        gj_nxt    = idx_b_r;
        ks_nxt    = ks_fwd;
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.out_byte       = data_r ^ ks_fwd;
          out_data_nxt.keystream_byte = ks_fwd;
          state_nxt                   = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.out_byte       = data_r ^ ks_r;
          out_data_nxt.keystream_byte = ks_r;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      gi_r        <= '0;
      gj_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      gi_r        <= gi_nxt;
      gj_r        <= gj_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_a_r    <= idx_a_nxt;
    idx_b_r    <= idx_b_nxt;
    idx_t_r    <= idx_t_nxt;
    sa_r       <= sa_nxt;
    sb_r       <= sb_nxt;
    data_r     <= data_nxt;
    ks_r       <= ks_nxt;
    out_data_r <= out_data_nxt;
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !mem_we)
    else $error("Permutation written while the unit is idle.");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_D_WR_J && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("Data beat finished without loading the output register.");

  a_key_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_K_WR_J && cnt_r == 8'hFF) |=> (gi_r == '0 && gj_r == '0 && in_ready))
    else $error("Key setup ended without clearing the generator indices.");

  a_hold_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD && !out_free) |=> (state_r == ST_HOLD && $stable(ks_r)))
    else $error("Held keystream byte lost while the output register was full.");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for rc4_stream_cipher_unit: key schedule and keystream generation.
// Depends on rc4_pkg for the beat types, command codes and register indexes.
// An in-bench cipher model predicts every result beat, which is checked as it arrives.
`timescale 1ns / 100ps

module testbench;

  localparam int IDLE_MAX      = 6;
  localparam int SETTLE_CYCLES = 1300;
  localparam int STALL_LIMIT   = 6000;
  localparam int TOTAL_BEATS   = 1800;

  localparam logic [rc4_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [rc4_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  rc4_pkg::in_beat_t             in_data;
  logic                          out_valid;
  logic                          out_ready;
  rc4_pkg::out_beat_t            out_data;
  logic                          cfg_we;
  logic [rc4_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rc4_pkg::KEY_W-1:0]     cfg_wdata;

  logic [rc4_pkg::BYTE_W-1:0] perm_model [rc4_pkg::PERM_DEPTH];
  logic [rc4_pkg::BYTE_W-1:0] gen_i;
  logic [rc4_pkg::BYTE_W-1:0] gen_j;
  logic [rc4_pkg::KEY_W-1:0]  key_lo_model;
  logic [rc4_pkg::KEY_W-1:0]  key_hi_model;
  rc4_pkg::out_beat_t         keystream_q [$];

  int  beats_sent;
  int  setups_sent;
  int  results_checked;
  int  mismatches;
  int  quiet_cycles;
  bit  idle_on;

  rc4_stream_cipher_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic schedule_key();
    int n;
    logic [rc4_pkg::BYTE_W-1:0] j;
    logic [rc4_pkg::BYTE_W-1:0] kb;
    logic [rc4_pkg::BYTE_W-1:0] t;
    j = '0;
    for (n = 0; n < rc4_pkg::PERM_DEPTH; n++) begin
      perm_model[n[rc4_pkg::BYTE_W-1:0]] = n[rc4_pkg::BYTE_W-1:0];
    end
    for (n = 0; n < rc4_pkg::PERM_DEPTH; n++) begin
      kb = ((n % 16) < 8) ? key_lo_model[8*(n%8) +: 8] : key_hi_model[8*(n%8) +: 8];
      j = j + perm_model[n[rc4_pkg::BYTE_W-1:0]] + kb;
      t = perm_model[n[rc4_pkg::BYTE_W-1:0]];
      perm_model[n[rc4_pkg::BYTE_W-1:0]] = perm_model[j];
      perm_model[j] = t;
    end
    gen_i = '0;
    gen_j = '0;
  endtask

  task automatic predict_beat(input rc4_pkg::in_beat_t beat);
    logic [rc4_pkg::BYTE_W-1:0] t;
    logic [rc4_pkg::BYTE_W-1:0] ks_index;
    rc4_pkg::out_beat_t         want;
    if (beat.command == rc4_pkg::CMD_KEY_SETUP) begin
      schedule_key();
      setups_sent++;
    end else begin
      gen_i = gen_i + 8'd1;
      gen_j = gen_j + perm_model[gen_i];
      t = perm_model[gen_i];
      perm_model[gen_i] = perm_model[gen_j];
      perm_model[gen_j] = t;
      ks_index = perm_model[gen_i] + perm_model[gen_j];
      want.keystream_byte = perm_model[ks_index];
      want.out_byte = beat.data_byte ^ want.keystream_byte;
      keystream_q.push_back(want);
    end
  endtask

  task automatic send_beat(input logic cmd, input logic [rc4_pkg::BYTE_W-1:0] data);
    rc4_pkg::in_beat_t beat;
    int                gap;
    beat.command   = cmd;
    beat.data_byte = data;
    gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat(beat);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic pause_input();
    in_valid <= 1'b0;
    while (keystream_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rc4_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rc4_pkg::KEY_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    if (idx == rc4_pkg::CFG_KEY_LOW) key_lo_model = value;
    else if (idx == rc4_pkg::CFG_KEY_HIGH) key_hi_model = value;
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
  endtask

  task automatic test_zero_key();
    idle_on = 1'b0;
    pause_input();
    write_reg(rc4_pkg::CFG_KEY_LOW, '0);
    write_reg(rc4_pkg::CFG_KEY_HIGH, '0);
    end_writes();
    send_beat(rc4_pkg::CMD_KEY_SETUP, 8'h00);
    send_beat(rc4_pkg::CMD_DATA, 8'h00);
    send_beat(rc4_pkg::CMD_DATA, 8'hFF);
    send_beat(rc4_pkg::CMD_DATA, 8'h00);
    send_beat(rc4_pkg::CMD_DATA, 8'hFF);
    send_beat(rc4_pkg::CMD_DATA, 8'h55);
    send_beat(rc4_pkg::CMD_DATA, 8'hAA);
  endtask

  task automatic test_ones_key();
    idle_on = 1'b1;
    pause_input();
    write_reg(rc4_pkg::CFG_KEY_LOW, '1);
    write_reg(rc4_pkg::CFG_KEY_HIGH, '1);
    end_writes();
    send_beat(rc4_pkg::CMD_KEY_SETUP, 8'hFF);
    send_beat(rc4_pkg::CMD_KEY_SETUP, 8'h5A);
    send_beat(rc4_pkg::CMD_DATA, 8'hFF);
    send_beat(rc4_pkg::CMD_DATA, 8'h00);
    send_beat(rc4_pkg::CMD_DATA, 8'hFF);
    send_beat(rc4_pkg::CMD_DATA, 8'h00);
    send_beat(rc4_pkg::CMD_DATA, 8'h80);
    send_beat(rc4_pkg::CMD_DATA, 8'h01);
  endtask

  // New key values and writes to unused indexes must not disturb the running keystream.
  task automatic test_key_held_until_setup();
    int n;
    idle_on = 1'b1;
    pause_input();
    write_reg(rc4_pkg::CFG_KEY_LOW, {$urandom, $urandom});
    write_reg(rc4_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
    write_reg(CFG_SPARE_2, '1);
    write_reg(CFG_SPARE_3, '1);
    end_writes();
    for (n = 0; n < 3; n++) send_beat(rc4_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
    send_beat(rc4_pkg::CMD_KEY_SETUP, 8'($urandom_range(0, 255)));
    for (n = 0; n < 3; n++) send_beat(rc4_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_stream();
    int n;
    int run;
    int pick;
    while (beats_sent < TOTAL_BEATS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 5);
      pause_input();
      case (pick)
        0: begin
          write_reg(rc4_pkg::CFG_KEY_LOW, '0);
          write_reg(rc4_pkg::CFG_KEY_HIGH, '0);
        end
        1: begin
          write_reg(rc4_pkg::CFG_KEY_LOW, '1);
          write_reg(rc4_pkg::CFG_KEY_HIGH, '1);
        end
        2: write_reg(rc4_pkg::CFG_KEY_LOW, {$urandom, $urandom});
        3: write_reg(rc4_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
        default: begin
          write_reg(rc4_pkg::CFG_KEY_LOW, {$urandom, $urandom});
          write_reg(rc4_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
        end
      endcase
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, {$urandom, $urandom});
      end
      end_writes();
      send_beat(rc4_pkg::CMD_KEY_SETUP, 8'($urandom_range(0, 255)));
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 600) : $urandom_range(1, 200);
      for (n = 0; n < run && beats_sent < TOTAL_BEATS; n++) begin
        if ($urandom_range(0, 99) == 0) begin
          send_beat(rc4_pkg::CMD_KEY_SETUP, 8'($urandom_range(0, 255)));
        end else begin
          send_beat(rc4_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    rc4_pkg::out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (keystream_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result beat: out_byte %02h keystream %02h",
                   out_data.out_byte, out_data.keystream_byte);
        end
      end else begin
        want = keystream_q.pop_front();
        results_checked++;
        if (out_data.out_byte !== want.out_byte ||
            out_data.keystream_byte !== want.keystream_byte) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch on result %0d: expected out_byte %02h keystream %02h, got %02h %02h",
                     results_checked, want.out_byte, want.keystream_byte,
                     out_data.out_byte, out_data.keystream_byte);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timed out with %0d results outstanding.", keystream_q.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = rc4_pkg::CFG_KEY_LOW;
    cfg_wdata    = '0;
    idle_on      = 1'b0;
    quiet_cycles = 0;
    key_lo_model = '0;
    key_hi_model = '0;
    gen_i        = '0;
    gen_j        = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_zero_key();
    test_ones_key();
    test_key_held_until_setup();
    test_random_stream();

    in_valid <= 1'b0;
    while (keystream_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d input beats including %0d key setups; checked %0d keystream results.",
             beats_sent, setups_sent, results_checked);
    $display("Mismatching result beats: %0d.", mismatches);
    if (mismatches == 0 && keystream_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rc4_pkg.sv
rtl/core/rc4_stream_cipher_unit.sv
test/testbench.sv
